// ----- design/sis_pkg.sv -----
// sis_pkg: shared types and constants for the stable insertion sorter
// no dependencies; used by sis_cell and stable_insertion_sorter
`default_nettype none

package sis_pkg;

   localparam int STORE_DEPTH = 16;
   localparam int KEY_W       = 32;
   localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [FILL_W-1:0]       fill_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic                    final_key;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] sorted_key;
      logic                    end_of_set;
      logic                    overflowed;
   } rsp_type;

   typedef enum logic {
      ST_LOAD  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   typedef struct packed {
      logic insert;     // insert the broadcast key this cycle
      logic shift_out;  // move every key one cell toward the output
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- design/sis_cell.sv -----
// sis_cell: one slot of the sorted chain, compares and shifts locally
// depends on sis_pkg
`default_nettype none

module sis_cell
   import sis_pkg::*;
(
   input  wire           clock,
   input  cell_ctrl_type ctrl,
   input  key_type       new_key,
   input  wire           occupied,
   input  key_type       prev_key,
   input  wire           prev_gt,
   input  key_type       next_key,
   output key_type       key,
   output logic          gt
);

   key_type key_ff;
   key_type key_in;

   // an empty slot acts as larger than anything; equal keys stay ahead
   assign gt  = !occupied || (key_ff > new_key);
   assign key = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctrl.shift_out) begin
         key_in = next_key;
      end else if (ctrl.insert) begin
         if (prev_gt) begin
            key_in = prev_key;
         end else if (gt) begin
            key_in = new_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

// ----- design/stable_insertion_sorter.sv -----
// stable_insertion_sorter: top level, chain of sis_cell slots plus load/drain control
// depends on sis_pkg and sis_cell
// loading takes one key per cycle; after the final beat the first sorted beat
// shows on the next cycle and the set drains one beat per cycle while rsp_stall
// is low; req_stall is held high for the whole drain
// reset: fill count, drop flag and state clear; slot contents stay unknown
`default_nettype none

module stable_insertion_sorter
   import sis_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   output rsp_type rsp_data
);

   // control state
   state_type state_ff, state_in;
   fill_type  fill_count_ff, fill_count_in;
   logic      drop_flag_ff, drop_flag_in;

   logic          req_beat;
   logic          rsp_beat;
   logic          store_full;
   cell_ctrl_type ctrl;

   // chain wiring, one entry per slot
   key_type cell_key [STORE_DEPTH];
   logic    cell_gt  [STORE_DEPTH];

   assign store_full = (fill_count_ff == FILL_W'(STORE_DEPTH));
   assign req_stall  = (state_ff == ST_DRAIN);
   assign rsp_valid  = (state_ff == ST_DRAIN);
   assign req_beat   = req_valid && !req_stall;
   assign rsp_beat   = rsp_valid && !rsp_stall;

   // slot 0 always faces the output; drain pulls keys toward it
   assign rsp_data.sorted_key = cell_key[0];
   assign rsp_data.end_of_set = (fill_count_ff == FILL_W'(1));
   assign rsp_data.overflowed = (fill_count_ff == FILL_W'(1)) && drop_flag_ff;

   // a full store drops the arriving key, final or not
   assign ctrl.insert    = req_beat && !store_full;
   assign ctrl.shift_out = rsp_beat;

   // the chain of slots
   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      key_type prev_key_w;
      logic    prev_gt_w;
      key_type next_key_w;

      if (i == 0) begin : g_head
         assign prev_key_w = req_data.key;
         assign prev_gt_w  = 1'b0;
      end else begin : g_body
         assign prev_key_w = cell_key[i-1];
         assign prev_gt_w  = cell_gt[i-1];
      end

      if (i == STORE_DEPTH - 1) begin : g_tail
         assign next_key_w = cell_key[i];
      end else begin : g_mid
         assign next_key_w = cell_key[i+1];
      end

      sis_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .new_key  (req_data.key),
         .occupied (fill_count_ff > FILL_W'(i)),
         .prev_key (prev_key_w),
         .prev_gt  (prev_gt_w),
         .next_key (next_key_w),
         .key      (cell_key[i]),
         .gt       (cell_gt[i])
      );
   end

   // load/drain sequencing
   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      drop_flag_in  = drop_flag_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_beat) begin
               if (store_full) begin
                  drop_flag_in = 1'b1;
               end else begin
                  fill_count_in = fill_count_ff + FILL_W'(1);
               end
               // final beat: the set always holds at least one key here
               if (req_data.final_key) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_beat) begin
               fill_count_in = fill_count_ff - FILL_W'(1);
               if (fill_count_ff == FILL_W'(1)) begin
                  drop_flag_in = 1'b0;
                  state_in     = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         fill_count_ff <= '0;
         drop_flag_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         drop_flag_ff  <= drop_flag_in;
      end
   end

   // never drain an empty set
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (fill_count_ff != '0))
      else $error("drain with empty store");

   // fill count stays within the chain
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= FILL_W'(STORE_DEPTH))
      else $error("fill count beyond store depth");

   // final key beat starts the drain
   a_final_drains: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_data.final_key) |=> (state_ff == ST_DRAIN))
      else $error("final beat did not start drain");

   // last beat of a set leaves a clean store
   a_set_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_data.end_of_set) |=> (fill_count_ff == '0 && !drop_flag_ff))
      else $error("store not cleared after set");

   // keys are only dropped when the store is full
   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      $rose(drop_flag_ff) |-> $past(store_full && req_beat))
      else $error("drop flag set without a full store");

endmodule

`default_nettype wire
